@@ sv/tgu_pkg.sv @@
`default_nettype none
package tgu_pkg;
  localparam logic [2:0] ACT_DIST  = 3'd0;
  localparam logic [2:0] ACT_EQUAL = 3'd1;
  localparam logic [2:0] ACT_PIC   = 3'd2;
  localparam logic [2:0] ACT_CI    = 3'd3;
  localparam logic [2:0] ACT_NORM  = 3'd4;
  localparam logic [2:0] ACT_IMG   = 3'd5;

  localparam logic [1:0] REG_HALF_SIZE = 2'd0;
  localparam logic [1:0] REG_TOLERANCE = 2'd1;

  typedef struct packed {
    logic signed [30:0] ax;
    logic signed [30:0] ay;
    logic signed [30:0] bx;
    logic signed [30:0] by;
    logic [29:0] radius_a;
    logic [29:0] radius_b;
    logic [2:0] action;
  } tgu_in_t;

  typedef struct packed {
    logic signed [17:0] unit_x;
    logic signed [17:0] unit_y;
    logic [30:0] distance;
    logic flag;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic last;
  } tgu_out_t;

  // One queued job as produced by the front end.
  typedef struct packed {
    logic [2:0] action;
    logic [31:0] mx;
    logic [31:0] my;
    logic sx;
    logic sy;
    logic big;
    logic signed [33:0] lim_pic;
    logic signed [33:0] lim_ci;
    logic [16:0] tol;
    logic signed [32:0] px0;
    logic signed [32:0] py0;
    logic signed [32:0] px1;
    logic signed [32:0] py1;
    logic cx;
    logic cy;
  } tgu_job_t;

  function automatic logic signed [32:0] wrap_c(input logic signed [32:0] c,
                                               input logic signed [32:0] r,
                                               input logic signed [32:0] h);
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    lo = 34'(r) - 34'(h);
    hi = 34'(h) - 34'(r);
    if (34'(c) >= lo && 34'(c) <= hi) begin
      return c;
    end else if (34'(c) < lo) begin
      return 33'(c + 2 * h);
    end else begin
      return 33'(c - 2 * h);
    end
  endfunction

  function automatic logic [31:0] nearest(input logic signed [30:0] a,
                                          input logic signed [30:0] b,
                                          input logic [29:0] h,
                                          output logic neg);
    logic signed [33:0] o0;
    logic signed [33:0] om;
    logic signed [33:0] op;
    logic signed [33:0] best;
    logic [33:0] m0;
    logic [33:0] mm;
    logic [33:0] mp;
    logic [33:0] bm;
    o0 = 34'(b) - 34'(a);
    om = o0 - 34'(2 * 34'(h));
    op = o0 + 34'(2 * 34'(h));
    m0 = o0 < 0 ? 34'(-o0) : 34'(o0);
    mm = om < 0 ? 34'(-om) : 34'(om);
    mp = op < 0 ? 34'(-op) : 34'(op);
    best = om;
    bm = mm;
    if (m0 <= bm) begin
      best = o0;
      bm = m0;
    end
    if (mp <= bm) begin
      best = op;
      bm = mp;
    end
    neg = best < 0;
    return bm[31:0];
  endfunction
endpackage
`default_nettype wire

@@ sv/tgu_if.sv @@
`default_nettype none
interface tgu_if #(parameter int W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/tgu_front.sv @@
`default_nettype none
module tgu_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [29:0] half_size,
  input  wire logic [15:0] tolerance,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire tgu_pkg::tgu_in_t in_item,
  output logic job_valid,
  input  wire logic job_ready,
  output tgu_pkg::tgu_job_t job
);
  tgu_pkg::tgu_job_t job_next;
  logic sx;
  logic sy;
  logic [31:0] mx;
  logic [31:0] my;
  logic signed [32:0] h;
  logic signed [32:0] r;
  logic signed [32:0] ax;
  logic signed [32:0] ay;
  logic signed [33:0] rb;
  logic signed [33:0] ra;
  logic signed [33:0] e;

  assign in_ready = !job_valid || job_ready;

  always_comb begin
    h = 33'(half_size);
    r = 33'(in_item.radius_a);
    ax = 33'(in_item.ax);
    ay = 33'(in_item.ay);
    rb = 34'(in_item.radius_b);
    ra = 34'(in_item.radius_a);
    e = 34'(tolerance);
    mx = tgu_pkg::nearest(in_item.ax, in_item.bx, half_size, sx);
    my = tgu_pkg::nearest(in_item.ay, in_item.by, half_size, sy);
    job_next.action = in_item.action;
    job_next.big = mx[31] | my[31];
    job_next.mx = job_next.big ? {1'b0, mx[31:1]} : mx;
    job_next.my = job_next.big ? {1'b0, my[31:1]} : my;
    job_next.sx = sx;
    job_next.sy = sy;
    job_next.lim_pic = rb - e;
    job_next.lim_ci = ra + rb - e;
    job_next.tol = 17'(tolerance);
    job_next.px0 = ax;
    job_next.py0 = ay;
    job_next.px1 = tgu_pkg::wrap_c(ax, r, h);
    job_next.py1 = tgu_pkg::wrap_c(ay, r, h);
    job_next.cx = (34'(ax) + ra > 34'(h)) || (34'(ax) - ra < -34'(h));
    job_next.cy = (34'(ay) + ra > 34'(h)) || (34'(ay) - ra < -34'(h));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_ready) begin
      job_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      job <= job_next;
    end
  end
endmodule
`default_nettype wire

@@ sv/tgu_fifo.sv @@
`default_nettype none
module tgu_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic wr_ready,
  input  wire logic [W-1:0] wr_data,
  output logic rd_valid,
  input  wire logic rd_ready,
  output logic [W-1:0] rd_data
);
  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0] cnt;
  logic do_wr;
  logic do_rd;

  assign wr_ready = cnt != (AW+1)'(DEPTH);
  assign rd_valid = cnt != '0;
  assign rd_data = mem[rp];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_rd) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
    if (do_wr) begin
      mem[wp] <= wr_data;
    end
  end

`ifndef SYNTH
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    cnt <= (AW+1)'(DEPTH)) else $error("queue overflow");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> cnt == $past(cnt) + 1'b1) else $error("count");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    cnt == '0 |-> !rd_valid) else $error("empty valid");
`endif
endmodule
`default_nettype wire

@@ sv/tgu_back.sv @@
`default_nettype none
module tgu_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  output logic job_ready,
  input  wire tgu_pkg::tgu_job_t job,
  output logic out_valid,
  input  wire logic out_ready,
  output tgu_pkg::tgu_out_t out_item
);
  // Pipeline: square (1), root 32 steps (4 per stage x 8), divide 18 steps
  // per axis (5 stages of up to 4 bits), then emit. Images emit up to four results.
  localparam int NS = 8;
  localparam int DS = 5;
  typedef struct packed {
    tgu_pkg::tgu_job_t j;
    logic [63:0] x;
    logic [63:0] res;
    logic [65:0] bitv;
  } sq_t;
  typedef struct packed {
    tgu_pkg::tgu_job_t j;
    logic [31:0] d;
    logic [49:0] nx;
    logic [49:0] ny;
    logic [17:0] qx;
    logic [17:0] qy;
  } dv_t;

  sq_t sq [NS+1];
  logic sv [NS+1];
  dv_t dv [DS+1];
  logic dvv [DS+1];
  logic adv;
  logic hold_valid;
  tgu_pkg::tgu_job_t hj;
  logic [31:0] hd;
  logic [17:0] hqx;
  logic [17:0] hqy;
  logic [1:0] idx;
  logic [1:0] n_res;
  logic em_done;

  assign adv = !hold_valid || (out_ready && em_done);
  assign job_ready = adv;

  always_comb begin
    n_res = 2'd0;
    if (hj.action == tgu_pkg::ACT_IMG) begin
      n_res = 2'(hj.cx) + 2'(hj.cy) + 2'(hj.cx & hj.cy);
    end
    em_done = idx == n_res;
  end

  always_ff @(posedge clk) begin
    logic [63:0] x;
    logic [63:0] res;
    logic [65:0] b;
    logic [49:0] nx;
    logic [49:0] ny;
    logic [17:0] qx;
    logic [17:0] qy;
    logic [49:0] dd;
    if (rst) begin
      for (int i = 0; i <= NS; i++) sv[i] <= 1'b0;
      for (int i = 0; i <= DS; i++) dvv[i] <= 1'b0;
      hold_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (adv) begin
        sv[0] <= job_valid;
        for (int i = 1; i <= NS; i++) sv[i] <= sv[i-1];
        dvv[0] <= sv[NS];
        for (int i = 1; i <= DS; i++) dvv[i] <= dvv[i-1];
        hold_valid <= dvv[DS];
        idx <= '0;
      end else if (hold_valid && out_ready) begin
        idx <= idx + 1'b1;
      end
    end
    if (adv) begin
      sq[0].j <= job;
      sq[0].x <= 64'(job.mx) * 64'(job.mx) + 64'(job.my) * 64'(job.my);
      sq[0].res <= '0;
      sq[0].bitv <= 66'(1) << 62;
      for (int s = 1; s <= NS; s++) begin
        x = sq[s-1].x;
        res = sq[s-1].res;
        b = sq[s-1].bitv;
        for (int k = 0; k < 4; k++) begin
          if (b != '0 && 66'(x) >= 66'(res) + b) begin
            x = 64'(66'(x) - 66'(res) - b);
            res = 64'((66'(res) >> 1) + b);
          end else begin
            res = res >> 1;
          end
          b = b >> 2;
        end
        sq[s].j <= sq[s-1].j;
        sq[s].x <= x;
        sq[s].res <= res;
        sq[s].bitv <= b;
      end
      dv[0].j <= sq[NS].j;
      dv[0].d <= sq[NS].res[31:0];
      dv[0].nx <= 50'(sq[NS].j.mx) << 17;
      dv[0].ny <= 50'(sq[NS].j.my) << 17;
      dv[0].qx <= '0;
      dv[0].qy <= '0;
      for (int s = 1; s <= DS; s++) begin
        nx = dv[s-1].nx;
        ny = dv[s-1].ny;
        qx = dv[s-1].qx;
        qy = dv[s-1].qy;
        for (int k = 0; k < 4; k++) begin
          if ((s-1)*4 + k < 18) begin
            dd = 50'(dv[s-1].d) << (17 - ((s-1)*4 + k));
            qx = qx << 1;
            qy = qy << 1;
            if (nx >= dd) begin
              nx = nx - dd;
              qx[0] = 1'b1;
            end
            if (ny >= dd) begin
              ny = ny - dd;
              qy[0] = 1'b1;
            end
          end
        end
        dv[s].j <= dv[s-1].j;
        dv[s].d <= dv[s-1].d;
        dv[s].nx <= nx;
        dv[s].ny <= ny;
        dv[s].qx <= qx;
        dv[s].qy <= qy;
      end
      hj <= dv[DS].j;
      hd <= dv[DS].d;
      hqx <= dv[DS].qx;
      hqy <= dv[DS].qy;
    end
  end

  // The quotient above is floor(m*2^17/d); rounding adds its low bit.
  logic [17:0] rx;
  logic [17:0] ry;
  logic [32:0] dfull;
  logic signed [33:0] di;
  always_comb begin
    rx = 18'((19'(hqx) + 19'(hqx[0])) >> 1);
    ry = 18'((19'(hqy) + 19'(hqy[0])) >> 1);
    if (rx > 18'd65536) rx = 18'd65536;
    if (ry > 18'd65536) ry = 18'd65536;
    if (hd == '0) begin
      rx = '0;
      ry = '0;
    end
    dfull = hj.big ? {hd, 1'b0} : 33'(hd);
    di = 34'(dfull);
    out_item = '0;
    out_item.last = em_done;
    case (hj.action)
      tgu_pkg::ACT_DIST, tgu_pkg::ACT_EQUAL, tgu_pkg::ACT_PIC, tgu_pkg::ACT_CI: begin
        out_item.unit_x = hj.sx ? -rx : rx;
        out_item.unit_y = hj.sy ? -ry : ry;
        out_item.distance = dfull[32:31] != 2'b00 ? 31'h7FFFFFFF : dfull[30:0];
        if (hj.action == tgu_pkg::ACT_EQUAL) out_item.flag = di < 34'(hj.tol);
        if (hj.action == tgu_pkg::ACT_PIC) out_item.flag = di <= hj.lim_pic;
        if (hj.action == tgu_pkg::ACT_CI) out_item.flag = di < hj.lim_ci;
      end
      tgu_pkg::ACT_NORM: begin
        out_item.pos_x = 32'(hj.px1);
        out_item.pos_y = 32'(hj.py1);
      end
      tgu_pkg::ACT_IMG: begin
        out_item.pos_x = 32'(hj.px0);
        out_item.pos_y = 32'(hj.py0);
        if (idx == 2'd1) begin
          out_item.pos_x = hj.cx ? 32'(hj.px1) : 32'(hj.px0);
          out_item.pos_y = hj.cx ? 32'(hj.py0) : 32'(hj.py1);
        end else if (idx == 2'd2) begin
          out_item.pos_x = 32'(hj.px0);
          out_item.pos_y = 32'(hj.py1);
        end else if (idx == 2'd3) begin
          out_item.pos_x = 32'(hj.px1);
          out_item.pos_y = 32'(hj.py1);
        end
      end
      default: begin
      end
    endcase
  end
  assign out_valid = hold_valid;

`ifndef SYNTH
  a_idx: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> idx <= n_res) else $error("image index");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !out_ready |=> hold_valid && $stable(idx)) else $error("hold");
  a_one: assert property (@(posedge clk) disable iff (rst)
    hold_valid && hj.action != tgu_pkg::ACT_IMG |-> out_item.last) else $error("last");
`endif
endmodule
`default_nettype wire

@@ sv/toroidal_geometry_unit_core.sv @@
`default_nettype none
// An item goes through the front register, the queue and the back end.
// Throughput: one item per cycle unless out_ready stalls; an images item
// holds the output until each of its results, up to four, is taken.
// Reset (rst, synchronous): clears the pipeline and queue, half_size to
// 65536000 and tolerance to 1.
module toroidal_geometry_unit_core #(
  parameter int QDEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [29:0] cfg_data,
  tgu_if.sink   in_ch,
  tgu_if.source out_ch
);
  logic [29:0] half_size;
  logic [15:0] tolerance;
  logic fv;
  logic fr;
  logic qv;
  logic qr;
  tgu_pkg::tgu_job_t fj;
  tgu_pkg::tgu_job_t qj;
  tgu_pkg::tgu_out_t oi;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_size <= 30'd65536000;
      tolerance <= 16'd1;
    end else if (cfg_we) begin
      if (cfg_index == tgu_pkg::REG_HALF_SIZE[0:0]) half_size <= cfg_data;
      else tolerance <= cfg_data[15:0];
    end
  end

  tgu_front u_front (.clk(clk), .rst(rst), .half_size(half_size), .tolerance(tolerance),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.data),
    .job_valid(fv), .job_ready(fr), .job(fj));

  tgu_fifo #(.W($bits(tgu_pkg::tgu_job_t)), .DEPTH(QDEPTH)) u_q (.clk(clk), .rst(rst),
    .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qj));

  tgu_back u_back (.clk(clk), .rst(rst), .job_valid(qv), .job_ready(qr), .job(qj),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(oi));

  assign out_ch.data = oi;
endmodule
`default_nettype wire

@@ bench/toroidal_geometry_unit_core_tb.sv @@
module toroidal_geometry_unit_core_tb;

  class geometry_scoreboard;
    tgu_pkg::tgu_out_t pending_results[$];
    logic [29:0] half;
    logic [15:0] tol;
    int mismatches;
    int results_seen;
    int items_noted;

    function new();
      half = 30'd65536000;
      tol = 16'd1;
      mismatches = 0;
      results_seen = 0;
      items_noted = 0;
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint closest_offset(longint a, longint b, longint h);
      longint best;
      longint off;
      best = b - 2 * h - a;
      for (int i = 0; i <= 1; i++) begin
        off = b + 2 * i * h - a;
        if (mag(off) <= mag(best)) best = off;
      end
      return best;
    endfunction

    function longint int_root(longint x);
      longint lo;
      longint hi;
      longint mid;
      lo = 0;
      hi = 64'd3037000500;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= x) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function longint unit_of(longint m, longint sgn, longint d);
      longint q;
      if (d == 0) return 0;
      q = (2 * (m * 65536) + d) / (2 * d);
      if (q > 65536) q = 65536;
      return sgn < 0 ? -q : q;
    endfunction

    function longint wrapped(longint c, longint r, longint h);
      if (c >= r - h && c <= h - r) return c;
      if (c < r - h) return c + 2 * h;
      return c - 2 * h;
    endfunction

    function logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function void push_pos(longint px, longint py, logic lst);
      tgu_pkg::tgu_out_t r;
      r = '0;
      r.pos_x = clip32(px);
      r.pos_y = clip32(py);
      r.last = lst;
      pending_results = {pending_results, r};
    endfunction

    function void note_item(tgu_pkg::tgu_in_t it);
      longint ax, ay, bx, by, ra, rb, h, e, dx, dy, mx, my, dh, d;
      tgu_pkg::tgu_out_t r;
      logic cx, cy;
      longint wx, wy;
      ax = it.ax; ay = it.ay; bx = it.bx; by = it.by;
      ra = it.radius_a; rb = it.radius_b; h = half; e = tol;
      items_noted++;
      r = '0;
      if (it.action <= tgu_pkg::ACT_CI) begin
        dx = closest_offset(ax, bx, h);
        dy = closest_offset(ay, by, h);
        mx = mag(dx); my = mag(dy);
        if (mx >= 64'd2147483648 || my >= 64'd2147483648) begin
          mx = mx >>> 1; my = my >>> 1;
          dh = int_root(mx * mx + my * my);
          d = 2 * dh;
        end else begin
          dh = int_root(mx * mx + my * my);
          d = dh;
        end
        r.unit_x = 18'(unit_of(mx, dx, dh));
        r.unit_y = 18'(unit_of(my, dy, dh));
        if (it.action == tgu_pkg::ACT_EQUAL) r.flag = d < e;
        else if (it.action == tgu_pkg::ACT_PIC) r.flag = d <= rb - e;
        else if (it.action == tgu_pkg::ACT_CI) r.flag = d < ra + rb - e;
        r.distance = d > 64'd2147483647 ? 31'h7fffffff : 31'(d);
        r.last = 1'b1;
        pending_results = {pending_results, r};
      end else if (it.action == tgu_pkg::ACT_NORM) begin
        push_pos(wrapped(ax, ra, h), wrapped(ay, ra, h), 1'b1);
      end else if (it.action == tgu_pkg::ACT_IMG) begin
        cx = (ax + ra > h) || (ax - ra < -h);
        cy = (ay + ra > h) || (ay - ra < -h);
        wx = wrapped(ax, ra, h);
        wy = wrapped(ay, ra, h);
        push_pos(ax, ay, !cx && !cy);
        if (cx) push_pos(wx, ay, !cy);
        if (cy) push_pos(ax, wy, !cx);
        if (cx && cy) push_pos(wx, wy, 1'b1);
      end else begin
        r.last = 1'b1;
        pending_results = {pending_results, r};
      end
    endfunction

    function void check_result(tgu_pkg::tgu_out_t got);
      tgu_pkg::tgu_out_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
        return;
      end
      want = pending_results.pop_front();
      if (got.unit_x !== want.unit_x || got.unit_y !== want.unit_y ||
          got.distance !== want.distance || got.flag !== want.flag ||
          got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result %0d: expected ux=%0d uy=%0d d=%0d f=%0b px=%0d py=%0d l=%0b",
                   results_seen, want.unit_x, want.unit_y, want.distance, want.flag,
                   want.pos_x, want.pos_y, want.last);
          $display("  actual   ux=%0d uy=%0d d=%0d f=%0b px=%0d py=%0d l=%0b",
                   got.unit_x, got.unit_y, got.distance, got.flag,
                   got.pos_x, got.pos_y, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [29:0] cfg_data;
  bit hold_output;
  bit allow_stalls;

  tgu_if #(.W($bits(tgu_pkg::tgu_in_t))) in_ch ();
  tgu_if #(.W($bits(tgu_pkg::tgu_out_t))) out_ch ();

  geometry_scoreboard board;

  toroidal_geometry_unit_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      board.note_item(tgu_pkg::tgu_in_t'(in_ch.data));
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      board.check_result(tgu_pkg::tgu_out_t'(out_ch.data));
    end
  end

  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_output) begin
        out_ch.ready <= 1'b0;
        @(negedge clk);
      end else begin
        g = allow_stalls ? gap_len() : 0;
        if (g > 0) begin
          out_ch.ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [29:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.half = (idx == tgu_pkg::REG_HALF_SIZE[0]) ? val : board.half;
    board.tol = (idx == tgu_pkg::REG_TOLERANCE[0]) ? val[15:0] : board.tol;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // The valid line stays high after an accepted item until the next gap or drain.
  task automatic send(tgu_pkg::tgu_in_t it);
    int g;
    g = allow_stalls ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [30:0] rand_coord(logic [29:0] h);
    int p;
    longint v;
    p = $urandom_range(0, 9);
    if (p < 5) v = longint'($urandom_range(0, 2 * h)) - h;
    else if (p < 8) begin
      v = longint'(h) - longint'($urandom_range(0, 64)) * ((($urandom & 1) != 0) ? 1 : -1);
    end
    else v = longint'({$urandom, $urandom}) % 64'sd1073741824;
    if (v > 64'sd1073741823) v = 64'sd1073741823;
    if (v < -64'sd1073741824) v = -64'sd1073741824;
    return 31'(v);
  endfunction

  function automatic tgu_pkg::tgu_in_t rand_item(logic [29:0] h);
    tgu_pkg::tgu_in_t it;
    it.action = $urandom_range(0, 99) < 95 ? 3'($urandom_range(0, 5)) :
                3'($urandom_range(6, 7));
    it.ax = rand_coord(h);
    it.ay = rand_coord(h);
    it.bx = rand_coord(h);
    it.by = rand_coord(h);
    it.radius_a = ($urandom & 3) == 0 ? 30'($urandom) : 30'($urandom_range(0, h));
    it.radius_b = ($urandom & 3) == 0 ? 30'($urandom) : 30'($urandom_range(0, h));
    if (it.radius_a > 30'd536870912) it.radius_a = 30'd536870912;
    if (it.radius_b > 30'd536870912) it.radius_b = 30'd536870912;
    return it;
  endfunction

  task automatic directed_items();
    tgu_pkg::tgu_in_t it;
    logic signed [30:0] lo;
    logic signed [30:0] hi;
    lo = 31'sh40000000;
    hi = 31'sh3fffffff;
    it = '0;
    for (int a = 0; a < 8; a++) begin
      it.action = 3'(a);
      send(it);
    end
    it = '{ax: lo, ay: hi, bx: hi, by: lo, radius_a: 30'd536870912,
           radius_b: 30'd536870912, action: tgu_pkg::ACT_CI};
    send(it);
    it.action = tgu_pkg::ACT_DIST; send(it);
    it.action = tgu_pkg::ACT_IMG; send(it);
    it.action = tgu_pkg::ACT_NORM; send(it);
    it = '{ax: 31'sd65536, ay: -31'sd65536, bx: 31'sd65536, by: -31'sd65536,
           radius_a: 30'd0, radius_b: 30'd65536, action: tgu_pkg::ACT_EQUAL};
    send(it);
    it.action = tgu_pkg::ACT_PIC; send(it);
    it = '{ax: -31'sd65536000, ay: 31'sd0, bx: 31'sd65536000, by: 31'sd0,
           radius_a: 30'd1000, radius_b: 30'd2000, action: tgu_pkg::ACT_DIST};
    send(it);
    it = '{ax: 31'sd65535000, ay: -31'sd65535000, bx: 0, by: 0,
           radius_a: 30'd100000, radius_b: 0, action: tgu_pkg::ACT_IMG};
    send(it);
    it.action = tgu_pkg::ACT_NORM; send(it);
    it = '{ax: 31'sd100, ay: 31'sd200, bx: 31'sd103, by: 31'sd204,
           radius_a: 30'd3, radius_b: 30'd3, action: tgu_pkg::ACT_CI};
    send(it);
    it.action = tgu_pkg::ACT_PIC; send(it);
  endtask

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) send(rand_item(board.half));
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    hold_output = 1'b0;
    allow_stalls = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_items();
    drain();
    write_reg(tgu_pkg::REG_HALF_SIZE[0], 30'd536870912);
    write_reg(tgu_pkg::REG_TOLERANCE[0], 30'd65535);
    directed_items();
    allow_stalls = 1'b1;
    random_items(50);
    drain();
    write_reg(tgu_pkg::REG_HALF_SIZE[0], 30'd1);
    write_reg(tgu_pkg::REG_TOLERANCE[0], 30'd0);
    random_items(30);
    drain();
    write_reg(tgu_pkg::REG_HALF_SIZE[0], 30'd65536000);
    write_reg(tgu_pkg::REG_TOLERANCE[0], 30'd300);
    fork
      begin
        hold_output = 1'b1;
        repeat (60) @(negedge clk);
        hold_output = 1'b0;
      end
      begin
        allow_stalls = 1'b0;
        random_items(20);
        allow_stalls = 1'b1;
      end
    join
    drain();
    write_reg(tgu_pkg::REG_HALF_SIZE[0], 30'($urandom_range(1000, 536870912)));
    write_reg(tgu_pkg::REG_TOLERANCE[0], 30'($urandom_range(0, 65535)));
    random_items(90);
    drain();
    $display("Covered %0d items and %0d results over five register settings,",
             board.items_noted, board.results_seen);
    $display("including extremes, wraparound, images and a long output stall.");
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
